// File: design/wca_pkg.sv
package wca_pkg;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_ADD    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_MEAN   = 3'd3,
      OP_COV    = 3'd4
   } cmd_op_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_WEIGHT = 2'd1;
   localparam logic [1:0] ST_NO_VAR    = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX = 2'd3;

   typedef struct packed {
      cmd_op_type         op;
      logic signed [15:0] value;
      logic [15:0]        weight;
      logic [2:0]         idx_lo;
      logic [2:0]         idx_hi;
      logic               normalize;
      logic               idx_bad;
   } cmd_type;

   typedef struct packed {
      logic items_allowed;
   } back_status_type;

   typedef enum logic [2:0] {
      AR_MUL  = 3'b001,
      AR_DIV  = 3'b010,
      AR_SQRT = 3'b100
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_ctl_type;

   localparam logic [127:0] ONE_Q16 = 128'd65536;

   // Saturates a sign and magnitude pair to a signed 48-bit word.
   function automatic logic [47:0] pack48(input logic neg, input logic [127:0] q);
      logic [47:0] lim;
      logic [47:0] m;
      lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      m = ((q[127:48] != '0) || (q[47:0] > lim)) ? lim : q[47:0];
      return neg ? (48'd0 - m) : m;
   endfunction

endpackage

// File: design/weighted_covariance_accumulator.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_type, req_sample_value, req_point_weight,
//                                             req_first_index, req_second_index, req_normalize
// rsp       out        rsp_valid / rsp_ready  rsp_stat_value, rsp_status
// csr       in         csr_wen                csr_wdata (dims_in_use)
//
// An add or remove word for element k does one read-modify-write of the product RAM for
// each element up to and including k. A mean and a covariance each end with a division in
// the shared bit-serial divider; a correlation adds two 64-step square roots. A clear word
// sweeps all MAX_DIM*(MAX_DIM+1)/2 entries of the product RAM. After reset the same sweep
// runs and req_ready stays low until it ends. A two-word queue sits between decode and
// execution, and a finished result waits in an output register while the next word is
// taken.
module weighted_covariance_accumulator import wca_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic signed [15:0] req_sample_value,
   input  logic [15:0]        req_point_weight,
   input  logic [2:0]         req_first_index,
   input  logic [2:0]         req_second_index,
   input  logic               req_normalize,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_stat_value,
   output logic [1:0]         rsp_status,
   input  logic               csr_wen,
   input  logic [3:0]         csr_wdata
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [3:0]       dims_ff;
   logic [DIM_W-1:0] dims;
   logic             push;
   cmd_type          push_cmd;
   logic             queue_full;
   logic             queue_empty;
   logic             pop;
   cmd_type          queue_head;
   back_status_type  back_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 4'd8;
      end else if (csr_wen) begin
         dims_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (dims_ff == 4'd0) begin
         dims = DIM_W'(1);
      end else if (8'(dims_ff) > 8'(MAX_DIM)) begin
         dims = DIM_W'(MAX_DIM);
      end else begin
         dims = DIM_W'(dims_ff);
      end
   end

   wca_front #(.MAX_DIM(MAX_DIM)) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_sample_value (req_sample_value),
      .req_point_weight (req_point_weight),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_normalize    (req_normalize),
      .dims             (dims),
      .back_status      (back_status),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   wca_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (queue_head)
   );

   wca_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock          (clock),
      .reset          (reset),
      .dims           (dims),
      .csr_wen        (csr_wen),
      .queue_empty    (queue_empty),
      .queue_head     (queue_head),
      .pop            (pop),
      .back_status    (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_stat_value (rsp_stat_value),
      .rsp_status     (rsp_status)
   );

endmodule

// File: design/wca_ram.sv
module wca_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/wca_front.sv
module wca_front import wca_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_type,
   input  logic signed [15:0]           req_sample_value,
   input  logic [15:0]                  req_point_weight,
   input  logic [2:0]                   req_first_index,
   input  logic [2:0]                   req_second_index,
   input  logic                         req_normalize,
   input  logic [$clog2(MAX_DIM+1)-1:0] dims,
   input  back_status_type              back_status,
   input  logic                         queue_full,
   output logic                         push,
   output cmd_type                      push_cmd
);

   logic       known;
   logic       bad_i;
   logic       bad_j;
   logic       swap;

   assign req_ready = back_status.items_allowed && !queue_full;

   always_comb begin
      known = 1'b1;
      push_cmd.op = OP_CLEAR;
      unique case (req_type)
         OP_CLEAR:  push_cmd.op = OP_CLEAR;
         OP_ADD:    push_cmd.op = OP_ADD;
         OP_REMOVE: push_cmd.op = OP_REMOVE;
         OP_MEAN:   push_cmd.op = OP_MEAN;
         OP_COV:    push_cmd.op = OP_COV;
         default: known = 1'b0;
      endcase
      bad_i = 8'(req_first_index) >= 8'(dims);
      bad_j = 8'(req_second_index) >= 8'(dims);
      swap = (req_type == OP_COV) && (req_first_index > req_second_index);
      push_cmd.value = req_sample_value;
      push_cmd.weight = req_point_weight;
      push_cmd.idx_lo = swap ? req_second_index : req_first_index;
      push_cmd.idx_hi = swap ? req_first_index : req_second_index;
      push_cmd.normalize = req_normalize;
      push_cmd.idx_bad = bad_i || ((req_type == OP_COV) && bad_j);
   end

   assign push = req_valid && req_ready && known;

endmodule

// File: design/wca_queue.sv
module wca_queue import wca_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff;
   logic [PW-1:0]    wr_in;
   logic [PW-1:0]    rd_ff;
   logic [PW-1:0]    rd_in;
   logic [PW:0]      cnt_ff;
   logic [PW:0]      cnt_in;

   assign full = cnt_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/wca_arith.sv
module wca_arith import wca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_ctl_type ctl,
   input  logic [127:0]  opa,
   input  logic [127:0]  opb,
   output logic          done,
   output logic [127:0]  result
);

   typedef enum logic [1:0] {
      A_IDLE = 2'b01,
      A_RUN  = 2'b10
   } arith_state_type;

   arith_state_type state_ff, state_in;
   arith_op_type    op_ff, op_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic [127:0]    rem_ff, rem_in;
   logic [127:0]    q_ff, q_in;
   logic [127:0]    aux_ff, aux_in;
   logic [127:0]    b_ff, b_in;
   logic            done_ff, done_in;

   logic [31:0]     pa;
   logic [31:0]     pb;
   logic [63:0]     pp;
   logic [127:0]    pp_shift;
   logic [128:0]    remsh;
   logic [129:0]    dd;
   logic [127:0]    t;
   logic [128:0]    sd;
   logic            last;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      aux_in = aux_ff;
      b_in = b_ff;
      done_in = 1'b0;

      pa = cnt_ff[1] ? aux_ff[63:32] : aux_ff[31:0];
      pb = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = 64'(pa) * 64'(pb);
      case (cnt_ff[1:0])
         2'b00:   pp_shift = {64'd0, pp};
         2'b11:   pp_shift = {pp, 64'd0};
         default: pp_shift = {32'd0, pp, 32'd0};
      endcase
      remsh = {rem_ff, aux_ff[127]};
      dd = {1'b0, remsh} - {2'b00, b_ff};
      t = q_ff + aux_ff;
      sd = {1'b0, rem_ff} - {1'b0, t};

      last = 1'b0;
      unique case (op_ff)
         AR_MUL:  last = cnt_ff == 7'd3;
         AR_DIV:  last = cnt_ff == 7'd127;
         AR_SQRT: last = cnt_ff == 7'd63;
         default: last = 1'b1;
      endcase

      unique case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               state_in = A_RUN;
               op_in = ctl.op;
               cnt_in = '0;
               q_in = '0;
               b_in = opb;
               if (ctl.op == AR_SQRT) begin
                  rem_in = opa;
                  aux_in = {2'b01, 126'd0};
               end else begin
                  rem_in = '0;
                  aux_in = opa;
               end
            end
         end
         A_RUN: begin
            unique case (op_ff)
               AR_MUL: begin
                  q_in = q_ff + pp_shift;
               end
               AR_DIV: begin
                  rem_in = dd[129] ? remsh[127:0] : dd[127:0];
                  q_in = {q_ff[126:0], !dd[129]};
                  aux_in = {aux_ff[126:0], 1'b0};
               end
               AR_SQRT: begin
                  if (!sd[128]) begin
                     rem_in = sd[127:0];
                     q_in = (q_ff >> 1) + aux_ff;
                  end else begin
                     q_in = q_ff >> 1;
                  end
                  aux_in = aux_ff >> 2;
               end
               default: begin
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               state_in = A_IDLE;
               done_in = 1'b1;
            end
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         op_ff <= AR_MUL;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      aux_ff <= aux_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign result = q_ff;

endmodule

// File: design/wca_back.sv
module wca_back import wca_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(MAX_DIM+1)-1:0] dims,
   input  logic                         csr_wen,
   input  logic                         queue_empty,
   input  cmd_type                      queue_head,
   output logic                         pop,
   output back_status_type              back_status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [47:0]           rsp_stat_value,
   output logic [1:0]                   rsp_status
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int TRI_DEPTH = (MAX_DIM * (MAX_DIM + 1)) / 2;
   localparam int AW = $clog2(TRI_DEPTH);

   typedef enum logic [17:0] {
      S_CLR      = 18'h00001,
      S_IDLE     = 18'h00002,
      S_UPD_WS   = 18'h00004,
      S_UPD_RD   = 18'h00008,
      S_UPD_WR   = 18'h00010,
      S_Q_START  = 18'h00020,
      S_CX_RD    = 18'h00040,
      S_CX_MUL1  = 18'h00080,
      S_CX_MUL2  = 18'h00100,
      S_CX_SUB   = 18'h00200,
      S_COV_DIV  = 18'h00400,
      S_NORM_CHK = 18'h00800,
      S_SQRT_J   = 18'h01000,
      S_CORR_MUL = 18'h02000,
      S_CORR_DIV = 18'h04000,
      S_PACK     = 18'h08000,
      S_FINISH   = 18'h10000,
      S_WAIT     = 18'h20000
   } back_state_type;

   back_state_type     state_ff, state_in;
   back_state_type     ret_ff, ret_in;
   cmd_type            cmd_ff, cmd_in;
   logic [DIM_W-1:0]   pos_ff, pos_in;
   logic signed [47:0] ws_ff [MAX_DIM];
   logic signed [47:0] ws_in [MAX_DIM];
   logic signed [47:0] n_ff, n_in;
   logic signed [15:0] buf_ff [MAX_DIM];
   logic signed [15:0] buf_in [MAX_DIM];
   logic signed [32:0] swv_ff, swv_in;
   logic signed [48:0] t_ff, t_in;
   logic [IDX_W-1:0]   m_ff, m_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               init_ff, init_in;
   logic [1:0]         ph_ff, ph_in;
   logic [IDX_W-1:0]   cx_i_ff, cx_i_in;
   logic [IDX_W-1:0]   cx_j_ff, cx_j_in;
   logic [63:0]        sa_ff, sa_in;
   logic               sa_neg_ff, sa_neg_in;
   logic [63:0]        sb_ff, sb_in;
   logic               sb_neg_ff, sb_neg_in;
   logic               p_neg_ff, p_neg_in;
   logic [127:0]       p1_ff, p1_in;
   logic [127:0]       a_ff, a_in;
   logic               a_neg_ff, a_neg_in;
   logic [127:0]       bi_ff, bi_in;
   logic               bi_neg_ff, bi_neg_in;
   logic [127:0]       bj_ff, bj_in;
   logic               bj_neg_ff, bj_neg_in;
   logic [63:0]        ri_ff, ri_in;
   logic               sign_ff, sign_in;
   logic               clamp_ff, clamp_in;
   logic [47:0]        res_val_ff, res_val_in;
   logic [1:0]         res_st_ff, res_st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_val_ff, rsp_val_in;
   logic [1:0]         rsp_st_ff, rsp_st_in;

   logic               ram_wen;
   logic [AW-1:0]      ram_waddr;
   logic [63:0]        ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [63:0]        ram_rdata;

   arith_ctl_type      ar_ctl;
   logic [127:0]       ar_a;
   logic [127:0]       ar_b;
   logic               ar_done;
   logic [127:0]       ar_res;

   logic [IDX_W-1:0]   ws_idx;
   logic signed [47:0] ws_rd;
   logic [63:0]        ws64;
   logic [63:0]        ws_mag;
   logic [63:0]        p_mag;
   logic [15:0]        tri_i;
   logic [15:0]        tri_base;
   logic [IDX_W-1:0]   k;
   logic signed [16:0] sw;
   logic signed [32:0] swv;
   logic signed [48:0] wsum;
   logic signed [48:0] nsum;
   logic signed [64:0] psum;
   logic [128:0]       sdiff;
   logic [127:0]       smag;
   logic               sneg;
   logic               s2neg;
   logic               pos_bi;
   logic               pos_bj;
   logic [127:0]       qclamp;

   wca_ram #(.WIDTH(64), .DEPTH(TRI_DEPTH)) u_prod_ram (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wca_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ar_ctl),
      .opa    (ar_a),
      .opb    (ar_b),
      .done   (ar_done),
      .result (ar_res)
   );

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cmd_in = cmd_ff;
      pos_in = pos_ff;
      ws_in = ws_ff;
      n_in = n_ff;
      buf_in = buf_ff;
      swv_in = swv_ff;
      t_in = t_ff;
      m_in = m_ff;
      k_in = k_ff;
      addr_in = addr_ff;
      clr_in = clr_ff;
      init_in = init_ff;
      ph_in = ph_ff;
      cx_i_in = cx_i_ff;
      cx_j_in = cx_j_ff;
      sa_in = sa_ff;
      sa_neg_in = sa_neg_ff;
      sb_in = sb_ff;
      sb_neg_in = sb_neg_ff;
      p_neg_in = p_neg_ff;
      p1_in = p1_ff;
      a_in = a_ff;
      a_neg_in = a_neg_ff;
      bi_in = bi_ff;
      bi_neg_in = bi_neg_ff;
      bj_in = bj_ff;
      bj_neg_in = bj_neg_ff;
      ri_in = ri_ff;
      sign_in = sign_ff;
      clamp_in = clamp_ff;
      res_val_in = res_val_ff;
      res_st_in = res_st_ff;
      rsp_val_in = rsp_val_ff;
      rsp_st_in = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      pop = 1'b0;
      ram_wen = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = '0;
      ram_raddr = addr_ff;
      ar_ctl.start = 1'b0;
      ar_ctl.op = AR_MUL;
      ar_a = '0;
      ar_b = '0;

      k = (8'(pos_ff) >= 8'(dims)) ? '0 : IDX_W'(pos_ff);

      ws_idx = IDX_W'(cmd_ff.idx_lo);
      if (state_ff == S_CX_RD) begin
         ws_idx = cx_i_ff;
      end else if (state_ff == S_CX_MUL1) begin
         ws_idx = cx_j_ff;
      end else if (state_ff == S_UPD_WS) begin
         ws_idx = k;
      end
      ws_rd = ws_ff[ws_idx];
      ws64 = {{16{ws_rd[47]}}, ws_rd};
      ws_mag = ws_rd[47] ? (64'd0 - ws64) : ws64;
      p_mag = ram_rdata[63] ? (64'd0 - ram_rdata) : ram_rdata;

      tri_i = 16'(cx_i_ff);
      tri_base = 16'((tri_i * (16'(2 * MAX_DIM + 1) - tri_i)) >> 1);

      sw = (cmd_ff.op == OP_ADD) ? $signed({1'b0, cmd_ff.weight})
                                 : -$signed({1'b0, cmd_ff.weight});
      swv = sw * cmd_ff.value;
      wsum = ws_rd + swv;
      nsum = n_ff + sw;
      psum = $signed(ram_rdata) + t_ff;

      s2neg = !(sa_neg_ff ^ sb_neg_ff);
      sdiff = {1'b0, p1_ff} - {1'b0, ar_res};
      if (p_neg_ff == s2neg) begin
         sneg = p_neg_ff;
         smag = p1_ff + ar_res;
      end else if (!sdiff[128]) begin
         sneg = p_neg_ff;
         smag = sdiff[127:0];
      end else begin
         sneg = s2neg;
         smag = 128'd0 - sdiff[127:0];
      end

      pos_bi = !bi_neg_ff && (bi_ff != '0);
      pos_bj = !bj_neg_ff && (bj_ff != '0);
      qclamp = (clamp_ff && (ar_res > ONE_Q16)) ? ONE_Q16 : ar_res;

      unique case (state_ff)
         S_CLR: begin
            ram_wen = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(TRI_DEPTH - 1)) begin
               init_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               cmd_in = queue_head;
               unique case (queue_head.op)
                  OP_CLEAR: begin
                     for (int d = 0; d < MAX_DIM; d++) begin
                        ws_in[d] = '0;
                     end
                     n_in = '0;
                     pos_in = '0;
                     clr_in = '0;
                     state_in = S_CLR;
                  end
                  OP_ADD, OP_REMOVE: state_in = S_UPD_WS;
                  default: state_in = S_Q_START;
               endcase
            end
         end
         S_UPD_WS: begin
            buf_in[k] = cmd_ff.value;
            swv_in = swv;
            if (wsum > 49'sh0_7FFF_FFFF_FFFF) begin
               ws_in[k] = 48'sh7FFF_FFFF_FFFF;
            end else if (wsum < -49'sh0_8000_0000_0000) begin
               ws_in[k] = 48'sh8000_0000_0000;
            end else begin
               ws_in[k] = wsum[47:0];
            end
            if (8'(k) + 8'd1 >= 8'(dims)) begin
               pos_in = '0;
               if (nsum > 49'sh0_7FFF_FFFF_FFFF) begin
                  n_in = 48'sh7FFF_FFFF_FFFF;
               end else if (nsum < -49'sh0_8000_0000_0000) begin
                  n_in = 48'sh8000_0000_0000;
               end else begin
                  n_in = nsum[47:0];
               end
            end else begin
               pos_in = DIM_W'(k) + 1'b1;
            end
            k_in = k;
            m_in = '0;
            addr_in = AW'(k);
            state_in = S_UPD_RD;
         end
         S_UPD_RD: begin
            ram_raddr = addr_ff;
            t_in = swv_ff * buf_ff[m_ff];
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            ram_wen = 1'b1;
            ram_waddr = addr_ff;
            if (psum[64] != psum[63]) begin
               ram_wdata = psum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
               ram_wdata = psum[63:0];
            end
            if (m_ff == k_ff) begin
               state_in = S_IDLE;
            end else begin
               m_in = m_ff + 1'b1;
               addr_in = AW'(16'(addr_ff) + 16'(MAX_DIM - 1) - 16'(m_ff));
               state_in = S_UPD_RD;
            end
         end
         S_Q_START: begin
            res_val_in = '0;
            if (cmd_ff.idx_bad) begin
               res_st_in = ST_BAD_INDEX;
               state_in = S_FINISH;
            end else if (n_ff[47] || (n_ff == '0)) begin
               res_st_in = ST_NO_WEIGHT;
               state_in = S_FINISH;
            end else if (cmd_ff.op == OP_MEAN) begin
               ar_ctl.start = 1'b1;
               ar_ctl.op = AR_DIV;
               ar_a = {48'd0, ws_mag, 16'd0};
               ar_b = {80'd0, n_ff};
               sign_in = ws_rd[47];
               clamp_in = 1'b0;
               ret_in = S_PACK;
               state_in = S_WAIT;
            end else begin
               ph_in = 2'd0;
               cx_i_in = IDX_W'(cmd_ff.idx_lo);
               cx_j_in = IDX_W'(cmd_ff.idx_hi);
               state_in = S_CX_RD;
            end
         end
         S_CX_RD: begin
            ram_raddr = AW'(tri_base + 16'(cx_j_ff) - tri_i);
            sa_in = ws_mag;
            sa_neg_in = ws_rd[47];
            state_in = S_CX_MUL1;
         end
         S_CX_MUL1: begin
            sb_in = ws_mag;
            sb_neg_in = ws_rd[47];
            p_neg_in = ram_rdata[63];
            ar_ctl.start = 1'b1;
            ar_ctl.op = AR_MUL;
            ar_a = {64'd0, p_mag};
            ar_b = {80'd0, n_ff};
            ret_in = S_CX_MUL2;
            state_in = S_WAIT;
         end
         S_CX_MUL2: begin
            p1_in = ar_res;
            ar_ctl.start = 1'b1;
            ar_ctl.op = AR_MUL;
            ar_a = {64'd0, sa_ff};
            ar_b = {64'd0, sb_ff};
            ret_in = S_CX_SUB;
            state_in = S_WAIT;
         end
         S_CX_SUB: begin
            case (ph_ff)
               2'd0: begin
                  a_in = smag;
                  a_neg_in = sneg;
               end
               2'd1: begin
                  bi_in = smag;
                  bi_neg_in = sneg;
               end
               default: begin
                  bj_in = smag;
                  bj_neg_in = sneg;
               end
            endcase
            if (!cmd_ff.normalize) begin
               ar_ctl.start = 1'b1;
               ar_ctl.op = AR_MUL;
               ar_a = {80'd0, n_ff};
               ar_b = {80'd0, n_ff};
               ret_in = S_COV_DIV;
               state_in = S_WAIT;
            end else if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
               cx_i_in = IDX_W'(cmd_ff.idx_lo);
               cx_j_in = IDX_W'(cmd_ff.idx_lo);
               state_in = S_CX_RD;
            end else if (ph_ff == 2'd1) begin
               ph_in = 2'd2;
               cx_i_in = IDX_W'(cmd_ff.idx_hi);
               cx_j_in = IDX_W'(cmd_ff.idx_hi);
               state_in = S_CX_RD;
            end else begin
               state_in = S_NORM_CHK;
            end
         end
         S_COV_DIV: begin
            ar_ctl.start = 1'b1;
            ar_ctl.op = AR_DIV;
            ar_a = {a_ff[111:0], 16'd0};
            ar_b = ar_res;
            sign_in = a_neg_ff;
            clamp_in = 1'b0;
            ret_in = S_PACK;
            state_in = S_WAIT;
         end
         S_NORM_CHK: begin
            if (!pos_bi || !pos_bj) begin
               res_st_in = ST_NO_VAR;
               state_in = S_FINISH;
            end else if (cmd_ff.idx_lo == cmd_ff.idx_hi) begin
               res_val_in = ONE_Q16[47:0];
               res_st_in = ST_OK;
               state_in = S_FINISH;
            end else begin
               ar_ctl.start = 1'b1;
               ar_ctl.op = AR_SQRT;
               ar_a = bi_ff;
               ret_in = S_SQRT_J;
               state_in = S_WAIT;
            end
         end
         S_SQRT_J: begin
            ri_in = ar_res[63:0];
            ar_ctl.start = 1'b1;
            ar_ctl.op = AR_SQRT;
            ar_a = bj_ff;
            ret_in = S_CORR_MUL;
            state_in = S_WAIT;
         end
         S_CORR_MUL: begin
            ar_ctl.start = 1'b1;
            ar_ctl.op = AR_MUL;
            ar_a = {64'd0, ri_ff};
            ar_b = {64'd0, ar_res[63:0]};
            ret_in = S_CORR_DIV;
            state_in = S_WAIT;
         end
         S_CORR_DIV: begin
            ar_ctl.start = 1'b1;
            ar_ctl.op = AR_DIV;
            ar_a = {a_ff[111:0], 16'd0};
            ar_b = ar_res;
            sign_in = a_neg_ff;
            clamp_in = 1'b1;
            ret_in = S_PACK;
            state_in = S_WAIT;
         end
         S_PACK: begin
            res_val_in = pack48(sign_ff, qclamp);
            res_st_in = ST_OK;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in = res_val_ff;
               rsp_st_in = res_st_ff;
               state_in = S_IDLE;
            end
         end
         S_WAIT: begin
            if (ar_done) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wen) begin
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         ret_ff <= S_IDLE;
         pos_ff <= '0;
         for (int d = 0; d < MAX_DIM; d++) begin
            ws_ff[d] <= '0;
         end
         n_ff <= '0;
         clr_ff <= '0;
         init_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         pos_ff <= pos_in;
         ws_ff <= ws_in;
         n_ff <= n_in;
         clr_ff <= clr_in;
         init_ff <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      buf_ff <= buf_in;
      swv_ff <= swv_in;
      t_ff <= t_in;
      m_ff <= m_in;
      k_ff <= k_in;
      addr_ff <= addr_in;
      ph_ff <= ph_in;
      cx_i_ff <= cx_i_in;
      cx_j_ff <= cx_j_in;
      sa_ff <= sa_in;
      sa_neg_ff <= sa_neg_in;
      sb_ff <= sb_in;
      sb_neg_ff <= sb_neg_in;
      p_neg_ff <= p_neg_in;
      p1_ff <= p1_in;
      a_ff <= a_in;
      a_neg_ff <= a_neg_in;
      bi_ff <= bi_in;
      bi_neg_ff <= bi_neg_in;
      bj_ff <= bj_in;
      bj_neg_ff <= bj_neg_in;
      ri_ff <= ri_in;
      sign_ff <= sign_in;
      clamp_ff <= clamp_in;
      res_val_ff <= res_val_in;
      res_st_ff <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign back_status.items_allowed = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_stat_value = rsp_val_ff;
   assign rsp_status = rsp_st_ff;

endmodule
